// ===== rtl/gbn_pkg.sv =====
package gbn_pkg;

   localparam int SEQ_W = 20;
   localparam int CNT_W = 21;
   localparam int CK_W  = 32;

   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic [ADDR_W-1:0] ADDR_TOTAL  = 3'd0;
   localparam logic [CNT_W-1:0]  TOTAL_RESET = 21'd1;

   typedef enum logic [1:0] {
      KIND_START,
      KIND_RECORD,
      KIND_ACK,
      KIND_TIMEOUT
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [SEQ_W-1:0]  seq;
      logic [CK_W-1:0]   checksum;
   } req_type;

   typedef struct packed {
      logic              send_valid;
      logic [SEQ_W-1:0]  send_seq;
      logic              is_retransmit;
      logic              last;
      logic              done_res;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MOD,
      ST_WRITE,
      ST_CHECK,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic mod_init;
      logic mod_step;
      logic mem_write;
      logic mem_read;
      logic ack_apply;
      logic timeout_setup;
      logic emit;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     emit_zero;
      logic     emit_one;
      logic     out_free;
   } status_type;

endpackage

// ===== rtl/go_back_n_sender_window.sv =====
// Go-Back-N sender window controller. Start, record, acknowledge and
// timeout items enter one at a time; each produces one or more transfers on
// the rsp channel, the final one flagged by last. An acknowledgement passes
// through accept, decode with checksum store read, check, emit. A record
// passes through accept, decode with a reciprocal multiply giving
// seq / WINDOW, remainder (the slot index seq mod WINDOW), checksum store
// write, emit. Start and timeout pass through accept and decode, then issue
// up to WINDOW requests at one transfer per cycle while rsp is not stalled;
// a stall on rsp holds the waiting transfer in place. The next item is accepted
// the cycle after the final transfer of the previous one is issued. The
// checksum store is not cleared at reset; acknowledging a slot that was never
// recorded gives an unspecified match result.
module go_back_n_sender_window #(
   parameter int WINDOW = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  gbn_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gbn_pkg::rsp_type               rsp_data,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [gbn_pkg::ADDR_W-1:0]     paddr,
   input  logic [gbn_pkg::DATA_W-1:0]     pwdata,
   output logic [gbn_pkg::DATA_W-1:0]     prdata,
   output logic                           pready
);
   import gbn_pkg::*;

   logic [CNT_W-1:0] total_ff;
   logic [CNT_W-1:0] total_in;
   cmd_type          cmd;
   status_type       status;

   assign pready = 1'b1;

   always_comb begin
      total_in = total_ff;
      if (psel && penable && pwrite && pready && paddr == ADDR_TOTAL) begin
         total_in = pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_RESET;
      end else begin
         total_ff <= total_in;
      end
   end

   assign prdata = (paddr == ADDR_TOTAL) ? DATA_W'(total_ff) : '0;

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gbn_dp #(
      .WINDOW (WINDOW)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_data      (req_data),
      .total_packets (total_ff),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .rsp_stall     (rsp_stall)
   );

endmodule

// ===== rtl/gbn_ctrl.sv =====
module gbn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gbn_pkg::status_type    status,
   output gbn_pkg::cmd_type       cmd
);
   import gbn_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.kind)
               KIND_START: begin
                  cmd.start = 1'b1;
                  state_in  = ST_SEND;
               end
               KIND_RECORD: begin
                  cmd.mod_init = 1'b1;
                  state_in     = ST_MOD;
               end
               KIND_ACK: begin
                  cmd.mem_read = 1'b1;
                  state_in     = ST_CHECK;
               end
               KIND_TIMEOUT: begin
                  cmd.timeout_setup = 1'b1;
                  state_in          = ST_SEND;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            state_in     = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.mem_write = 1'b1;
            state_in      = ST_SEND;
         end
         ST_CHECK: begin
            cmd.ack_apply = 1'b1;
            state_in      = ST_SEND;
         end
         ST_SEND: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.emit_zero || status.emit_one) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/gbn_dp.sv =====
module gbn_dp #(
   parameter int WINDOW = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gbn_pkg::cmd_type              cmd,
   output gbn_pkg::status_type           status,
   input  gbn_pkg::req_type              req_data,
   input  logic [gbn_pkg::CNT_W-1:0]     total_packets,
   output logic                          rsp_valid,
   output gbn_pkg::rsp_type              rsp_data,
   input  logic                          rsp_stall
);
   import gbn_pkg::*;

   localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int AW = $clog2(WINDOW + 1);
   localparam int LW = $clog2(WINDOW);
   localparam int RSH = SEQ_W + LW;
   localparam int PROD_W = 2 * SEQ_W + 1;
   localparam logic [SEQ_W:0]    RECIP    =
      (SEQ_W+1)'(((64'd1 << RSH) + 64'(WINDOW - 1)) / 64'(WINDOW));
   localparam logic [SW-1:0]     SLOT_MAX = SW'(WINDOW - 1);
   localparam logic [AW-1:0]     WIN_A    = AW'(WINDOW);
   localparam logic [CNT_W-1:0]  WIN_C    = CNT_W'(WINDOW);
   localparam logic [SEQ_W-1:0]  WIN_S    = SEQ_W'(WINDOW);
   localparam logic [SEQ_W-1:0]  SEQ_MAX  = '1;

   req_type               item_ff;
   logic                  started_ff,      started_in;
   logic [SEQ_W-1:0]      window_base_ff,  window_base_in;
   logic [SEQ_W-1:0]      next_seq_ff,     next_seq_in;
   logic [CNT_W-1:0]      packets_left_ff, packets_left_in;
   logic [AW-1:0]         acks_ff,         acks_in;
   logic [SW-1:0]         base_slot_ff,    base_slot_in;
   logic [AW-1:0]         emit_cnt_ff,     emit_cnt_in;
   logic [SEQ_W-1:0]      emit_seq_ff,     emit_seq_in;
   logic                  retx_ff,         retx_in;
   logic [SEQ_W-1:0]      quot_ff,         quot_in;
   logic [SW-1:0]         rem_ff,          rem_in;
   logic                  rsp_valid_ff,    rsp_valid_in;
   rsp_type               rsp_data_ff,     rsp_data_in;
   logic [CK_W-1:0]       rd_data_ff;
   logic [CK_W-1:0]       slot_ck_mem [WINDOW];

   logic                  ack_ok;
   logic [AW-1:0]         acks_inc;
   logic [CNT_W-1:0]      left_dec;
   logic [SEQ_W-1:0]      outstanding;
   logic [AW-1:0]         tmo_cnt;
   logic [SW-1:0]         base_slot_nx;
   logic [PROD_W-1:0]     quot_prod;
   logic [SEQ_W-1:0]      rem_full;
   logic                  done;

   function automatic logic [AW-1:0] batch_size(input logic [CNT_W-1:0] left);
      return (left < WIN_C) ? AW'(left) : WIN_A;
   endfunction

   // seq / WINDOW by reciprocal multiply, exact over the full seq range
   assign quot_prod = PROD_W'(item_ff.seq) * PROD_W'(RECIP);
   assign rem_full  = item_ff.seq - quot_ff * WIN_S;

   assign ack_ok = started_ff && (packets_left_ff != '0) && (window_base_ff != next_seq_ff)
                   && (item_ff.seq == window_base_ff) && (item_ff.checksum == rd_data_ff);
   assign acks_inc    = acks_ff + AW'(1);
   assign left_dec    = packets_left_ff - CNT_W'(1);
   assign outstanding = next_seq_ff - window_base_ff;
   assign tmo_cnt     = !started_ff ? '0 :
                        (outstanding < WIN_S) ? AW'(outstanding) : WIN_A;
   assign base_slot_nx = (window_base_ff == SEQ_MAX || base_slot_ff == SLOT_MAX) ? '0 :
                         base_slot_ff + SW'(1);
   assign done = started_ff && (packets_left_ff == '0);

   always_comb begin
      started_in      = started_ff;
      window_base_in  = window_base_ff;
      next_seq_in     = next_seq_ff;
      packets_left_in = packets_left_ff;
      acks_in         = acks_ff;
      base_slot_in    = base_slot_ff;
      emit_cnt_in     = emit_cnt_ff;
      emit_seq_in     = emit_seq_ff;
      retx_in         = retx_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;

      if (cmd.start) begin
         started_in      = 1'b1;
         window_base_in  = '0;
         next_seq_in     = '0;
         acks_in         = '0;
         packets_left_in = total_packets;
         base_slot_in    = '0;
         emit_cnt_in     = batch_size(total_packets);
         emit_seq_in     = '0;
         retx_in         = 1'b0;
      end

      if (cmd.mod_init) begin
         quot_in     = SEQ_W'(quot_prod >> RSH);
         emit_cnt_in = '0;
      end

      if (cmd.mod_step) begin
         rem_in = rem_full[SW-1:0];
      end

      if (cmd.ack_apply) begin
         emit_cnt_in = '0;
         emit_seq_in = next_seq_ff;
         retx_in     = 1'b0;
         if (ack_ok) begin
            window_base_in  = window_base_ff + SEQ_W'(1);
            packets_left_in = left_dec;
            base_slot_in    = base_slot_nx;
            if (acks_inc >= WIN_A) begin
               acks_in     = '0;
               emit_cnt_in = batch_size(left_dec);
            end else begin
               acks_in = acks_inc;
            end
         end
      end

      if (cmd.timeout_setup) begin
         emit_cnt_in = tmo_cnt;
         emit_seq_in = window_base_ff;
         retx_in     = 1'b1;
      end

      if (cmd.emit) begin
         rsp_valid_in              = 1'b1;
         rsp_data_in.send_valid    = (emit_cnt_ff != '0);
         rsp_data_in.send_seq      = (emit_cnt_ff != '0) ? emit_seq_ff : '0;
         rsp_data_in.is_retransmit = (emit_cnt_ff != '0) && retx_ff;
         rsp_data_in.last          = (emit_cnt_ff <= AW'(1));
         rsp_data_in.done_res      = done;
         if (emit_cnt_ff != '0) begin
            emit_cnt_in = emit_cnt_ff - AW'(1);
            emit_seq_in = emit_seq_ff + SEQ_W'(1);
            if (!retx_ff) begin
               next_seq_in = next_seq_ff + SEQ_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff      <= 1'b0;
         window_base_ff  <= '0;
         next_seq_ff     <= '0;
         packets_left_ff <= '0;
         acks_ff         <= '0;
         base_slot_ff    <= '0;
         emit_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         started_ff      <= started_in;
         window_base_ff  <= window_base_in;
         next_seq_ff     <= next_seq_in;
         packets_left_ff <= packets_left_in;
         acks_ff         <= acks_in;
         base_slot_ff    <= base_slot_in;
         emit_cnt_ff     <= emit_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      emit_seq_ff <= emit_seq_in;
      retx_ff     <= retx_in;
      quot_ff     <= quot_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_write) begin
         slot_ck_mem[rem_ff] <= item_ff.checksum;
      end
      if (cmd.mem_read) begin
         rd_data_ff <= slot_ck_mem[base_slot_ff];
      end
   end

   assign status.kind      = item_ff.kind;
   assign status.emit_zero = (emit_cnt_ff == '0);
   assign status.emit_one  = (emit_cnt_ff == AW'(1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
